[rtl/sound_level_window_alarm_top_assert.svh]
// Assertion macros used by the sound-level window alarm top level.
`ifndef SOUND_LEVEL_WINDOW_ALARM_TOP_ASSERT_SVH
`define SOUND_LEVEL_WINDOW_ALARM_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SLWA_ASSERT_NOW(lbl, ck, rs, trig, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define SLWA_ASSERT_NEXT(lbl, ck, rs, trig, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/slwa_pkg.sv]
// Shared constants for the sound-level window alarm.
package slwa_pkg;

  localparam int DEFAULT_WINDOW_SIZE = 40;

  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 8;
  localparam int INTERVAL_W = 16;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 16'd50;
  localparam logic [THR_W-1:0]      RST_MEAN_THRESHOLD  = 8'd20;
  localparam logic [THR_W-1:0]      RST_PEAK_THRESHOLD  = 8'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD  = 2'd2;

endpackage

[rtl/slwa_window.sv]
// Sample window memory: one write port, one registered read port, valid bits.
module slwa_window
  import slwa_pkg::*;
#(
  parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE,
  localparam int POS_W = $clog2(WINDOW_SIZE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [POS_W-1:0]   waddr,
  input  logic [LEVEL_W-1:0] wdata,
  input  logic [POS_W-1:0]   raddr,
  output logic [LEVEL_W-1:0] rdata
);

  logic [LEVEL_W-1:0]     mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] valid;
  logic [LEVEL_W-1:0]     rd_word;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

[rtl/sound_level_window_alarm_top.sv]
// Top level of the sound-level window alarm.
//
// Each input word carries a millisecond time and an 8-bit sound level. The
// level is written into a circular window of WINDOW_SIZE entries when the
// time since the last stored level (modulo 2^32) strictly exceeds
// sample_interval; a running sum follows every store. Then the whole window
// is read back one entry per cycle to find its maximum, and the alarm is
// raised when sum > mean_threshold * WINDOW_SIZE and maximum > peak_threshold.
// One result word follows every input word. The scan through the single read
// port of the window memory sets the time an item takes; the next input word
// is accepted while the previous result still waits in the output register.
// The window starts all zero after reset through per-entry valid bits, so no
// clearing pass is needed.
`include "sound_level_window_alarm_top_assert.svh"

module sound_level_window_alarm_top
  import slwa_pkg::*;
#(
  parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms, [39:32] sample
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] alarm, [1] sample_taken, rest zero
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W  = $clog2(WINDOW_SIZE);
  localparam int SCAN_W = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = $clog2(WINDOW_SIZE * 255 + 1);
  localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(WINDOW_SIZE * 255);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW_SIZE - 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(WINDOW_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [INTERVAL_W-1:0] sample_interval;
  logic [THR_W-1:0]      mean_threshold;
  logic [THR_W-1:0]      peak_threshold;

  // Block state and working registers
  logic [POS_W-1:0]   wr_pos;
  logic [SUM_W-1:0]   running_sum;
  logic [TIME_W-1:0]  last_time;
  logic [TIME_W-1:0]  now_q;
  logic [LEVEL_W-1:0] level_q;
  logic               taken_q;
  logic [SCAN_W-1:0]  scan_idx;
  logic [LEVEL_W-1:0] peak;
  logic               alarm_q;
  logic               taken_out;

  // Window memory access
  logic               mem_we;
  logic [POS_W-1:0]   mem_raddr;
  logic [LEVEL_W-1:0] mem_rdata;

  logic               in_fire;
  logic               out_free;
  logic               store;
  logic [TIME_W-1:0]  elapsed;
  logic [SUM_W-1:0]   mean_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= RST_SAMPLE_INTERVAL;
      mean_threshold  <= RST_MEAN_THRESHOLD;
      peak_threshold  <= RST_PEAK_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_INTERVAL: sample_interval <= cfg_data;
        CFG_MEAN_THRESHOLD:  mean_threshold  <= cfg_data[THR_W-1:0];
        CFG_PEAK_THRESHOLD:  peak_threshold  <= cfg_data[THR_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Strictly-greater interval test on the wrapped time difference.
  assign elapsed = now_q - last_time;
  assign store   = (state == ST_UPDATE) && (elapsed > TIME_W'(sample_interval));

  assign mean_limit = SUM_W'(32'(mean_threshold) * 32'(WINDOW_SIZE));

  // Read the slot about to be replaced while idle, then sweep during the scan.
  assign mem_we    = store;
  assign mem_raddr = (state == ST_SCAN) ? scan_idx[POS_W-1:0] : wr_pos;

  slwa_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (wr_pos),
    .wdata (level_q),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wr_pos      <= '0;
      running_sum <= '0;
      last_time   <= '0;
      m_tvalid    <= 1'b0;
      scan_idx    <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            now_q   <= s_tdata[TIME_W-1:0];
            level_q <= s_tdata[TIME_W +: LEVEL_W];
            state   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // mem_rdata holds the old entry at wr_pos.
          taken_q  <= store;
          peak     <= '0;
          scan_idx <= '0;
          if (store) begin
            running_sum <= running_sum - SUM_W'(mem_rdata) + SUM_W'(level_q);
            last_time   <= now_q;
            wr_pos      <= (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
          end
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // Data returns in the cycle after its address: compare the previous read.
          if (scan_idx != '0 && mem_rdata > peak) begin
            peak <= mem_rdata;
          end
          if (scan_idx == SCAN_END) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_DONE: begin
          // Hold here until the output register frees up.
          if (out_free) begin
            alarm_q   <= (running_sum > mean_limit) && (peak > peak_threshold);
            taken_out <= taken_q;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 2){1'b0}}, taken_out, alarm_q};

  `SLWA_ASSERT_NOW(a_sum_bound, clk, rst, 1'b1, running_sum <= SUM_MAX, "running sum out of range")
  `SLWA_ASSERT_NOW(a_pos_bound, clk, rst, 1'b1, wr_pos <= POS_LAST, "write position past window")
  `SLWA_ASSERT_NEXT(a_result_out, clk, rst, (state == ST_DONE) && out_free, m_tvalid && (state == ST_IDLE), "result word not presented")

endmodule
